/* rtl/core/kfc_pkg.sv */
package kfc_pkg;

   localparam int BodyLen = 43;

   localparam logic [5:0] CrcStartIdx = 6'd2;
   localparam logic [5:0] CrcLastIdx  = 6'd42;
   localparam logic [5:0] TrailerIdx  = 6'd43;
   localparam logic [5:0] LastIdx     = 6'd46;

   localparam logic [7:0] SyncFirst  = 8'h5A;
   localparam logic [7:0] SyncSecond = 8'hA5;
   localparam logic [7:0] StatusOk   = 8'h01;

   localparam logic [31:0] CrcPoly = 32'h82F63B78;
   localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic init;
      logic absorb;
      logic finish;
      logic emit;
   } crc_ctl_type;

   // reflected CRC-32C, one byte, LSB first
   function automatic logic [31:0] crc32c_byte(logic [31:0] crc_value, byte_type data);
      logic [31:0] c;
      c = crc_value ^ {24'd0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* rtl/core/key_frame_crc32c_formatter.sv */
// channel   direction  handshake             payload
// req_      in         req_valid/req_stall   key_ident, key_word_a..d
// rsp_      out        rsp_valid/rsp_stall   frame_byte, last_byte
//
// One record becomes 47 bytes, one per cycle while rsp_stall stays low, sent
// from the single-byte output of the shift chain.
// A record is taken in the same cycle the previous frame's last byte leaves.
// The CRC is folded in as bytes 2 to 42 leave the head of a 43-cell byte chain.
// Reset (synchronous) empties the block; rsp_stall holds the current byte.
module key_frame_crc32c_formatter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_key_ident,
   input  logic [63:0] req_key_word_a,
   input  logic [63:0] req_key_word_b,
   input  logic [63:0] req_key_word_c,
   input  logic [63:0] req_key_word_d,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last_byte
);

   logic                 busy_ff;
   logic                 busy_in;
   logic [5:0]           idx_ff;
   logic [5:0]           idx_in;
   logic                 req_accept;
   logic                 advance;
   logic                 at_last;
   kfc_pkg::byte_type    load_bytes [kfc_pkg::BodyLen];
   kfc_pkg::byte_type    cell_q     [kfc_pkg::BodyLen];
   kfc_pkg::byte_type    crc_byte;
   kfc_pkg::crc_ctl_type crc_ctl;

   assign advance    = busy_ff && !rsp_stall;
   assign at_last    = (idx_ff == kfc_pkg::LastIdx);
   assign req_stall  = busy_ff && !(advance && at_last);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      load_bytes[0]  = kfc_pkg::SyncFirst;
      load_bytes[1]  = kfc_pkg::SyncSecond;
      for (int k = 0; k < 8; k++) begin
         load_bytes[2 + k]  = req_key_ident[63 - 8 * k -: 8];
         load_bytes[10 + k] = req_key_word_a[63 - 8 * k -: 8];
         load_bytes[18 + k] = req_key_word_b[63 - 8 * k -: 8];
         load_bytes[26 + k] = req_key_word_c[63 - 8 * k -: 8];
         load_bytes[34 + k] = req_key_word_d[63 - 8 * k -: 8];
      end
      load_bytes[kfc_pkg::BodyLen - 1] = kfc_pkg::StatusOk;
   end

   for (genvar i = 0; i < kfc_pkg::BodyLen; i++) begin : g_cell
      kfc_pkg::byte_type next_byte;
      if (i == kfc_pkg::BodyLen - 1) begin : g_tail
         assign next_byte = 8'h00;
      end else begin : g_link
         assign next_byte = cell_q[i + 1];
      end
      kfc_byte_cell u_cell (
         .clock     (clock),
         .load      (req_accept),
         .shift     (advance),
         .load_byte (load_bytes[i]),
         .next_byte (next_byte),
         .byte_out  (cell_q[i])
      );
   end

   always_comb begin
      crc_ctl.init   = req_accept;
      crc_ctl.absorb = advance && (idx_ff >= kfc_pkg::CrcStartIdx)
                       && (idx_ff < kfc_pkg::CrcLastIdx);
      crc_ctl.finish = advance && (idx_ff == kfc_pkg::CrcLastIdx);
      crc_ctl.emit   = advance && (idx_ff >= kfc_pkg::TrailerIdx);
   end

   kfc_crc_unit u_crc (
      .clock     (clock),
      .ctl       (crc_ctl),
      .data_byte (cell_q[0]),
      .crc_byte  (crc_byte)
   );

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      priority if (req_accept) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (advance) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   assign rsp_valid      = busy_ff;
   assign rsp_frame_byte = (idx_ff < kfc_pkg::TrailerIdx) ? cell_q[0] : crc_byte;
   assign rsp_last_byte  = busy_ff && at_last;

   a_idx_range : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= kfc_pkg::LastIdx))
      else $error("frame index out of range");

   a_frame_start : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (rsp_valid && rsp_frame_byte == kfc_pkg::SyncFirst && !rsp_last_byte))
      else $error("frame does not open with sync byte");

   a_drain : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_byte && !req_valid) |=> !rsp_valid)
      else $error("output still valid after last byte");

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (req_accept && busy_ff) |-> (advance && at_last))
      else $error("record taken while a frame is in flight");

endmodule

/* rtl/core/kfc_byte_cell.sv */
module kfc_byte_cell (
   input  logic              clock,
   input  logic              load,
   input  logic              shift,
   input  kfc_pkg::byte_type load_byte,
   input  kfc_pkg::byte_type next_byte,
   output kfc_pkg::byte_type byte_out
);

   kfc_pkg::byte_type byte_ff;
   kfc_pkg::byte_type byte_in;

   always_comb begin
      priority if (load) begin
         byte_in = load_byte;
      end else if (shift) begin
         byte_in = next_byte;
      end else begin
         byte_in = byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign byte_out = byte_ff;

endmodule

/* rtl/core/kfc_crc_unit.sv */
module kfc_crc_unit (
   input  logic                 clock,
   input  kfc_pkg::crc_ctl_type ctl,
   input  kfc_pkg::byte_type    data_byte,
   output kfc_pkg::byte_type    crc_byte
);

   logic [31:0] crc_ff;
   logic [31:0] crc_in;

   always_comb begin
      priority if (ctl.init) begin
         crc_in = kfc_pkg::CrcInit;
      end else if (ctl.finish) begin
         crc_in = ~kfc_pkg::crc32c_byte(crc_ff, data_byte);
      end else if (ctl.absorb) begin
         crc_in = kfc_pkg::crc32c_byte(crc_ff, data_byte);
      end else if (ctl.emit) begin
         crc_in = {crc_ff[23:0], 8'h00};
      end else begin
         crc_in = crc_ff;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   // most significant byte goes out first
   assign crc_byte = crc_ff[31:24];

endmodule

/* dv/key_frame_crc32c_formatter_tb.sv */
`timescale 1ns / 1ps

module key_frame_crc32c_formatter_tb;

   localparam int FrameLen     = 47;
   localparam int CrcFirstIdx  = 2;
   localparam int CrcSpanLen   = 41;
   localparam int StatusIdx    = 42;
   localparam int CycleLimit   = 500000;
   localparam int DrainCycles  = 60;
   localparam logic [7:0]  SyncHi      = 8'h5A;
   localparam logic [7:0]  SyncLo      = 8'hA5;
   localparam logic [7:0]  StatusByte  = 8'h01;
   localparam logic [31:0] Crc32cPoly  = 32'h82F63B78;
   localparam logic [31:0] Crc32cSeed  = 32'hFFFFFFFF;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } frame_beat_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_key_ident;
   logic [63:0] req_key_word_a;
   logic [63:0] req_key_word_b;
   logic [63:0] req_key_word_c;
   logic [63:0] req_key_word_d;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_last_byte;

   frame_beat_type pending_beats[$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          calm_link   = 1'b1;

   key_frame_crc32c_formatter DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_key_ident  (req_key_ident),
      .req_key_word_a (req_key_word_a),
      .req_key_word_b (req_key_word_b),
      .req_key_word_c (req_key_word_c),
      .req_key_word_d (req_key_word_d),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // build the 47-byte frame for one record and queue its bytes
   function automatic void predict_key_frame(input logic [63:0] ident,
                                             input logic [63:0] wa,
                                             input logic [63:0] wb,
                                             input logic [63:0] wc,
                                             input logic [63:0] wd);
      logic [7:0]  frame [FrameLen];
      logic [63:0] words [5];
      logic [31:0] crc;
      frame_beat_type beat;
      words[0] = ident;
      words[1] = wa;
      words[2] = wb;
      words[3] = wc;
      words[4] = wd;
      frame[0] = SyncHi;
      frame[1] = SyncLo;
      for (int w = 0; w < 5; w++) begin
         for (int i = 0; i < 8; i++) begin
            frame[2 + 8 * w + i] = words[w][63 - 8 * i -: 8];
         end
      end
      frame[StatusIdx] = StatusByte;
      // reflected CRC-32C, bit at a time
      crc = Crc32cSeed;
      for (int k = CrcFirstIdx; k < CrcFirstIdx + CrcSpanLen; k++) begin
         crc = crc ^ {24'd0, frame[k]};
         for (int b = 0; b < 8; b++) begin
            crc = crc[0] ? ((crc >> 1) ^ Crc32cPoly) : (crc >> 1);
         end
      end
      crc = crc ^ Crc32cSeed;
      frame[43] = crc[31:24];
      frame[44] = crc[23:16];
      frame[45] = crc[15:8];
      frame[46] = crc[7:0];
      for (int k = 0; k < FrameLen; k++) begin
         beat.frame_byte = frame[k];
         beat.last_byte  = (k == FrameLen - 1);
         pending_beats.push_back(beat);
      end
   endfunction

   // offer one record; hold it until taken
   task automatic send_key_record(input logic [63:0] ident,
                                  input logic [63:0] wa,
                                  input logic [63:0] wb,
                                  input logic [63:0] wc,
                                  input logic [63:0] wd);
      int gap;
      if (!calm_link && $urandom_range(99) < 13) begin
         gap = $urandom_range(1, 47);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_key_ident  <= ident;
      req_key_word_a <= wa;
      req_key_word_b <= wb;
      req_key_word_c <= wc;
      req_key_word_d <= wd;
      req_valid      <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_key_frame(ident, wa, wb, wc, wd);
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   task automatic test_directed_records();
      logic [63:0] ramp [4];
      for (int w = 0; w < 4; w++) begin
         for (int i = 0; i < 8; i++) begin
            ramp[w][63 - 8 * i -: 8] = 8'(8 * w + i);
         end
      end
      calm_link = 1'b1;
      send_key_record('0, '0, '0, '0, '0);
      send_key_record('1, '1, '1, '1, '1);
      send_key_record('1, '0, '0, '0, '0);
      send_key_record('0, '1, '1, '1, '1);
      send_key_record({32{2'b10}}, {32{2'b01}}, {32{2'b10}}, {32{2'b01}}, {32{2'b10}});
      send_key_record({32{2'b01}}, {32{2'b10}}, {32{2'b01}}, {32{2'b10}}, {32{2'b01}});
      send_key_record(64'h0123456789ABCDEF, ramp[0], ramp[1], ramp[2], ramp[3]);
      send_key_record(64'h8000000000000000, 64'h8000000000000000, 64'h1,
                      64'h8000000000000000, 64'h1);
      send_key_record(64'h1, 64'h1, 64'h8000000000000000, 64'h1,
                      64'h8000000000000000);
      // payload that mimics the sync and status bytes
      send_key_record({4{16'h5AA5}}, {4{16'h5AA5}}, {8{8'h01}}, {4{16'hA55A}},
                      {8{8'h01}});
      calm_link = 1'b0;
      for (int n = 0; n < 4; n++) begin
         send_key_record(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
      end
   endtask

   task automatic test_back_to_back_records();
      calm_link = 1'b1;
      for (int n = 0; n < 60; n++) begin
         send_key_record(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
      end
      calm_link = 1'b0;
   endtask

   task automatic test_random_records();
      logic [63:0] words [5];
      calm_link = 1'b0;
      for (int n = 0; n < 345; n++) begin
         for (int w = 0; w < 5; w++) begin
            case ($urandom_range(9))
               0: words[w] = '0;
               1: words[w] = '1;
               default: words[w] = rand_word();
            endcase
         end
         send_key_record(words[0], words[1], words[2], words[3], words[4]);
      end
   endtask

   always @(posedge clock) begin
      if (reset || calm_link) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 13);
      end
   end

   // compare each accepted byte with the oldest expected one
   always @(posedge clock) begin
      frame_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            $error("unexpected frame byte %h, last_byte %b", rsp_frame_byte, rsp_last_byte);
            error_count++;
         end else begin
            want = pending_beats.pop_front();
            if (rsp_frame_byte !== want.frame_byte) begin
               $error("frame_byte: expected %h, actual %h", want.frame_byte, rsp_frame_byte);
               error_count++;
            end
            if (rsp_last_byte !== want.last_byte) begin
               $error("last_byte: expected %b, actual %b", want.last_byte, rsp_last_byte);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("key_frame_crc32c_formatter_tb: FAIL");
         $finish;
      end
   end

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_key_ident  <= '0;
      req_key_word_a <= '0;
      req_key_word_b <= '0;
      req_key_word_c <= '0;
      req_key_word_d <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_records();
      test_back_to_back_records();
      test_random_records();
      req_valid <= 1'b0;

      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0 && pending_beats.size() == 0) begin
         $display("key_frame_crc32c_formatter_tb: PASS");
      end else begin
         $display("key_frame_crc32c_formatter_tb: FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/kfc_pkg.sv
rtl/core/kfc_byte_cell.sv
rtl/core/kfc_crc_unit.sv
rtl/core/key_frame_crc32c_formatter.sv
dv/key_frame_crc32c_formatter_tb.sv
